// ===== design/sxb_pkg.sv =====
`timescale 1ns / 1ps

package sxb_pkg;

    // Item kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Pixels held in one word of the frame store
    localparam int PIXELS_PER_WORD = 8;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] origin_x;
        logic [7:0] origin_y;
        logic [3:0] row_offset;
        logic [7:0] pattern;
        logic       first_row;
        logic [7:0] read_index;
    } sxb_item_t;

    typedef struct packed {
        logic       collision;
        logic [7:0] read_data;
    } sxb_result_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLEAR  = 5'b00010,
        ST_FETCH  = 5'b00100,
        ST_MODIFY = 5'b01000,
        ST_RESULT = 5'b10000
    } sxb_state_t;

endpackage

// ===== design/sprite_xor_blitter.sv =====
`timescale 1ns / 1ps

// One-bit frame store with an XOR sprite-row drawer and collision flag.
// Input channel item/item_valid/item_ready takes one transaction at a time:
// a clear, a draw of one 8-pixel sprite row, or a read of 8 stored pixels.
// Output channel result/result_valid/result_ready returns one transaction
// per item: the collision flag after the item and, for a read, the pixels.
// The store is organised as FRAME_PIXELS/8 bytes in a single-port memory;
// every step of an item goes through that one port and one XOR/compare unit.
// A draw does a read-modify-write of two adjacent bytes, a read fetches one
// byte, an unused kind passes straight to its result, and a clear zeroes
// every byte, one byte per cycle.
// After reset the block runs a clearing pass over all FRAME_PIXELS/8 bytes
// (256 at the defaults) before item_ready rises; the collision flag resets
// to zero. A finished result waits in an output register, so the next item
// is accepted while it is pending; if the receiver still stalls when that
// next item completes, the block holds it until the register frees.
// FRAME_PIXELS and ROW_PIXELS are powers of two.
module sprite_xor_blitter #(
    parameter int FRAME_PIXELS = 2048,
    parameter int ROW_PIXELS   = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sxb_pkg::sxb_item_t   item,
    input  logic                 item_valid,
    output logic                 item_ready,
    output sxb_pkg::sxb_result_t result,
    output logic                 result_valid,
    input  logic                 result_ready
);
    import sxb_pkg::*;

    localparam int WORDS  = FRAME_PIXELS / PIXELS_PER_WORD;
    localparam int PIX_W  = $clog2(FRAME_PIXELS);
    localparam int WORD_W = PIX_W - 3;
    localparam int SUM_W  = 10 + $clog2(ROW_PIXELS);

    // Frame store
    logic [7:0]        mem [WORDS];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic [WORD_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;

    // Control and working registers
    sxb_state_t        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              half_reg, half_next;
    logic [15:0]       mask_reg, mask_next;
    logic [WORD_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_item_reg, clr_item_next;
    logic              flag_reg, flag_next;
    logic [7:0]        rdout_reg, rdout_next;
    logic              out_valid_reg, out_valid_next;
    sxb_result_t       out_data_reg, out_data_next;

    // Address arithmetic for an incoming item
    logic [8:0]          line;
    logic [SUM_W-1:0]    pix_sum;
    logic [PIX_W-1:0]    pix;
    logic [15:0]         item_mask;
    logic [WORD_W+7:0]   ridx_wide;
    logic [7:0]          byte_mask;
    logic                accept;
    logic                out_free;

    assign line      = 9'(item.origin_y) + 9'(item.row_offset);
    assign pix_sum   = SUM_W'(item.origin_x) + SUM_W'(line) * SUM_W'(ROW_PIXELS);
    assign pix       = pix_sum[PIX_W-1:0];
    assign item_mask = {item.pattern, 8'h00} >> pix[2:0];
    assign ridx_wide = (WORD_W + 8)'(item.read_index);
    assign byte_mask = half_reg ? mask_reg[7:0] : mask_reg[15:8];

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Sequence the shared memory port and XOR unit
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        word_next      = word_reg;
        half_next      = half_reg;
        mask_next      = mask_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_item_next  = clr_item_reg;
        flag_next      = flag_reg;
        rdout_next     = rdout_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_addr       = word_reg + WORD_W'(half_reg);
        mem_wdata      = rdata_reg ^ byte_mask;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = item.kind;
                    half_next  = 1'b0;
                    mask_next  = item_mask;
                    rdout_next = 8'h00;
                    case (item.kind)
                        KIND_CLEAR:
                        begin
                            clr_cnt_next  = '0;
                            clr_item_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        KIND_DRAW:
                        begin
                            word_next  = pix[PIX_W-1:3];
                            state_next = ST_FETCH;
                            if (item.first_row)
                            begin
                                flag_next = 1'b0;
                            end
                        end
                        KIND_READ:
                        begin
                            word_next  = ridx_wide[WORD_W-1:0];
                            state_next = ST_FETCH;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                // Zero one byte a cycle
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = 8'h00;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == WORD_W'(WORDS - 1))
                begin
                    state_next = clr_item_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                // Address issued above; data lands in rdata_reg
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (op_reg == KIND_READ)
                begin
                    rdout_next = rdata_reg;
                    state_next = ST_RESULT;
                end
                else
                begin
                    // Toggle the masked pixels and note any lit one
                    mem_we = 1'b1;
                    if ((rdata_reg & byte_mask) != 8'h00)
                    begin
                        flag_next = 1'b1;
                    end
                    if (!half_reg)
                    begin
                        half_next  = 1'b1;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT:
            begin
                // Hold until the output register frees
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.collision = flag_reg;
                    out_data_next.read_data = rdout_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory port with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        word_reg     <= word_next;
        half_reg     <= half_next;
        mask_reg     <= mask_next;
        rdout_reg    <= rdout_next;
        out_data_reg <= out_data_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_item_reg  <= 1'b0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_item_reg  <= clr_item_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== test/sprite_xor_blitter_chk.sv =====
`timescale 1ns / 1ps

module sprite_xor_blitter_chk #(
    parameter int FRAME_PIXELS = 2048,
    parameter int ROW_PIXELS   = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sxb_pkg::sxb_item_t   item,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  sxb_pkg::sxb_result_t result,
    input  logic                 result_valid,
    input  logic                 result_ready,
    output int                   mismatch_count,
    output int                   readouts_owed
);
    import sxb_pkg::*;

    // Shadow copy of the frame and the collision flag
    bit          shadow_pix [FRAME_PIXELS];
    bit          shadow_flag;
    sxb_result_t owed_readouts [$];

    // Apply one transaction to the shadow frame and return the readout it earns
    function automatic sxb_result_t blit_item(input sxb_item_t it);
        sxb_result_t r;
        int          line_no;
        int          addr;
        r = '0;
        case (it.kind)
            KIND_CLEAR:
            begin
                foreach (shadow_pix[i])
                    shadow_pix[i] = 1'b0;
            end
            KIND_DRAW:
            begin
                if (it.first_row)
                    shadow_flag = 1'b0;
                line_no = int'(it.origin_y) + int'(it.row_offset);
                for (int j = 0; j < 8; j++)
                begin
                    if (it.pattern[7 - j])
                    begin
                        addr = (int'(it.origin_x) + j + line_no * ROW_PIXELS) % FRAME_PIXELS;
                        if (shadow_pix[addr])
                            shadow_flag = 1'b1;
                        shadow_pix[addr] = ~shadow_pix[addr];
                    end
                end
            end
            KIND_READ:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    addr = (int'(it.read_index) * 8 + j) % FRAME_PIXELS;
                    r.read_data[7 - j] = shadow_pix[addr];
                end
            end
            default:
            begin
                // unused kind: frame and flag stay as they are
            end
        endcase
        r.collision = shadow_flag;
        return r;
    endfunction

    // Compare each returned transaction, then book the one just accepted
    always @(posedge clk or negedge rst_n)
    begin
        sxb_result_t want;
        int          errs;
        errs = 0;
        if (!rst_n)
        begin
            foreach (shadow_pix[i])
                shadow_pix[i] = 1'b0;
            shadow_flag = 1'b0;
            owed_readouts.delete();
            mismatch_count <= 0;
            readouts_owed  <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (owed_readouts.size() == 0)
                begin
                    $error("result transaction with nothing owed: collision %0b read_data %02h",
                           result.collision, result.read_data);
                    errs++;
                end
                else
                begin
                    want = owed_readouts.pop_front();
                    if (result.collision !== want.collision)
                    begin
                        $error("collision: expected %0b, got %0b",
                               want.collision, result.collision);
                        errs++;
                    end
                    if (result.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %02h, got %02h",
                               want.read_data, result.read_data);
                        errs++;
                    end
                end
            end
            if (item_valid && item_ready)
                owed_readouts.push_back(blit_item(item));
            mismatch_count <= mismatch_count + errs;
            readouts_owed  <= owed_readouts.size();
        end
    end

endmodule

// ===== test/sprite_xor_blitter_tb.sv =====
`timescale 1ns / 1ps

module sprite_xor_blitter_tb;
    import sxb_pkg::*;

    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         ROW_PIXELS     = 64;
    localparam int         FRAME_PIXELS   = 2048;
    localparam int         TARGET_ITEMS   = 1750;
    localparam int         STALL_LIMIT    = 5000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    sxb_item_t   item         = '0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    sxb_result_t result;
    logic        result_valid;
    logic        result_ready = 1'b0;

    int mismatch_count;
    int readouts_owed;
    int send_idle_pct = 10;
    int recv_idle_pct = 69;
    int items_sent    = 0;
    int stall_cycles  = 0;

    always #5 clk = ~clk;

    sprite_xor_blitter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    sprite_xor_blitter_chk #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .ROW_PIXELS   (ROW_PIXELS)
    ) chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .result         (result),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .mismatch_count (mismatch_count),
        .readouts_owed  (readouts_owed)
    );

    // Stall the receiver at random
    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic sxb_item_t make_item(input logic [1:0] kind, input logic [7:0] x,
                                            input logic [7:0] y, input logic [3:0] row,
                                            input logic [7:0] pat, input logic first,
                                            input logic [7:0] ridx);
        sxb_item_t it;
        it.kind       = kind;
        it.origin_x   = x;
        it.origin_y   = y;
        it.row_offset = row;
        it.pattern    = pat;
        it.first_row  = first;
        it.read_index = ridx;
        return it;
    endfunction

    // Group index holding the leftmost pixel of a sprite row
    function automatic logic [7:0] group_of(input logic [7:0] x, input int line_no);
        return 8'(((int'(x) + line_no * ROW_PIXELS) % FRAME_PIXELS) / 8);
    endfunction

    // Present one transaction; called and returning at a falling edge
    task automatic send_item(input sxb_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        if (it.kind != KIND_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every owed readout is back
    task automatic drain;
        item_valid <= 1'b0;
        @(negedge clk);
        while (readouts_owed != 0)
            @(negedge clk);
    endtask

    task automatic send_noise;
        send_item(make_item(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                            4'($urandom), 8'($urandom), 1'($urandom), 8'($urandom)));
    endtask

    // Sprite of random height, rows in order, then reads over where it landed
    task automatic send_sprite;
        logic [7:0] x;
        logic [7:0] y;
        int         height;
        int         line_no;
        x      = 8'($urandom);
        y      = 8'($urandom);
        height = $urandom_range(15);
        if ($urandom_range(9) == 0)
            height = 0;
        if (height == 0)
            send_item(make_item(KIND_DRAW, x, y, 4'($urandom), 8'h00, 1'b1, 8'($urandom)));
        for (int row = 0; row < height; row++)
        begin
            // now and then break the sequence with a stray first-row mark
            send_item(make_item(KIND_DRAW, x, y, 4'(row), 8'($urandom),
                                (row == 0) || ($urandom_range(19) == 0), 8'($urandom)));
        end
        line_no = int'(y) + $urandom_range(15);
        send_item(make_item(KIND_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), 1'($urandom), group_of(x, line_no)));
        send_item(make_item(KIND_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), 1'($urandom), group_of(x, line_no) + 8'd1));
    endtask

    task automatic directed_items;
        send_item(make_item(KIND_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 8'h00));
        send_item(make_item(KIND_DRAW,  8'h00, 8'h00, 4'h0, 8'hFF, 1'b1, 8'h00));
        send_item(make_item(KIND_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 8'h00));
        // redraw the same row: every pixel collides
        send_item(make_item(KIND_DRAW,  8'h00, 8'h00, 4'h0, 8'hFF, 1'b0, 8'h00));
        // height-zero sprite clears the flag only
        send_item(make_item(KIND_DRAW,  8'h11, 8'h22, 4'h3, 8'h00, 1'b1, 8'hFF));
        // row that runs off the right edge onto the next line
        send_item(make_item(KIND_DRAW,  8'd60, 8'h00, 4'h0, 8'hFF, 1'b1, 8'h00));
        send_item(make_item(KIND_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 8'd7));
        send_item(make_item(KIND_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 8'd8));
        // largest origin and row offset wrap round the frame
        send_item(make_item(KIND_DRAW,  8'hFF, 8'hFF, 4'hF, 8'h81, 1'b1, 8'h00));
        send_item(make_item(KIND_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 8'd143));
        send_item(make_item(KIND_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 8'd144));
        send_item(make_item(KIND_DRAW,  8'hFF, 8'hFF, 4'hF, 8'h80, 1'b0, 8'h00));
        // clear keeps the collision flag
        send_item(make_item(KIND_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 8'hFF));
        send_item(make_item(KIND_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 8'd143));
        send_item(make_item(KIND_UNUSED, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 8'hFF));
        // last pixel of the frame, spilling over to the first
        send_item(make_item(KIND_DRAW,  8'd63, 8'd31, 4'h0, 8'hFF, 1'b1, 8'h00));
        send_item(make_item(KIND_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 8'hFF));
        send_item(make_item(KIND_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 8'h00));
        send_item(make_item(KIND_DRAW,  8'hAA, 8'h55, 4'hA, 8'h55, 1'b0, 8'hAA));
        send_item(make_item(KIND_READ,  8'h55, 8'hAA, 4'h5, 8'hAA, 1'b1, 8'h55));
    endtask

    initial
    begin
        int pick;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_items();
        drain();

        while (items_sent < TARGET_ITEMS)
        begin
            // swap the idling between the phases, draining at each boundary
            if (items_sent >= TARGET_ITEMS / 3 && send_idle_pct == 10)
            begin
                drain();
                send_idle_pct = 69;
                recv_idle_pct = 10;
            end
            else if (items_sent >= 2 * TARGET_ITEMS / 3 && send_idle_pct == 69)
            begin
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 55)
                send_sprite();
            else if (pick < 80)
                send_item(make_item(KIND_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                                    8'($urandom), 1'($urandom), 8'($urandom)));
            else if (pick < 97)
                send_noise();
            else
                send_item(make_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                                    8'($urandom), 1'($urandom), 8'($urandom)));
        end

        // let the last readouts come back, then allow a few draw times more
        drain();
        repeat (30) @(negedge clk);
        if (mismatch_count == 0 && readouts_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sxb_pkg.sv
design/sprite_xor_blitter.sv
test/sprite_xor_blitter_chk.sv
test/sprite_xor_blitter_tb.sv
